>>> hdl/greedy_word_wrap_spans_macros.svh
// Assertion macros shared by the word wrap RTL.
`ifndef GREEDY_WORD_WRAP_SPANS_MACROS_SVH
`define GREEDY_WORD_WRAP_SPANS_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GWWS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gwws: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define GWWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gwws: next-cycle check failed");

`endif

>>> hdl/gwws_pkg.sv
// Types and constants shared by the greedy word wrap span block.
package gwws_pkg;

   // Character codes
   localparam logic [7:0] CH_END   = 8'd0;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;

   localparam logic [15:0] WRAP_WIDTH_RESET = 16'd80;
   localparam logic [15:0] SAT16            = 16'hFFFF;
   localparam int          MAX_TEXT_DEFAULT = 65536;

   // Result queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   // One emitted line
   typedef struct packed {
      logic        last;
      logic [15:0] widest_line;
      logic [15:0] line_number;
      logic [15:0] line_length;
      logic [15:0] line_start;
   } rsp_item_type;

   // Results caused by the character on the input
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type res1;
      rsp_item_type res0;
   } step_out_type;

endpackage

>>> hdl/greedy_word_wrap_spans.sv
// Greedy word wrap span generator: takes one text character per cycle
// (req_tdata, byte 0 ends a text) and returns one item per emitted line with
// its start, length, line number and widest line so far; rsp_tlast marks the
// last line caused by a character. A character is accepted every cycle while
// the four-entry result queue has room for two lines; its lines are written
// to the queue and leave on the result channel one per cycle while rsp_tready
// is high. A character that ends a line by both a wrap and a newline (or end
// of text) yields two lines and so needs two result channel transfers, which
// limits the sustained rate when such characters come densely.
`include "greedy_word_wrap_spans_macros.svh"

module greedy_word_wrap_spans import gwws_pkg::*; #(
   parameter int MAX_TEXT = MAX_TEXT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: wrap width
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // text characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   // line spans
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] line_start, [31:16] line_length,
                                    // [47:32] line_number, [63:48] widest_line
   output logic        rsp_tlast    // last_of_run
);

   logic [15:0]       wrap_width_ff;
   logic              req_accept, rsp_accept;
   step_out_type      step;
   rsp_item_type      q_mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic [1:0]        push_n;
   rsp_item_type      head;

   // Wrap width register
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_width_ff <= WRAP_WIDTH_RESET;
      end else if (csr_wr_en) begin
         wrap_width_ff <= csr_wr_data;
      end
   end

   assign req_tready = (count_ff <= (QPTR_W+1)'(QDEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   gwws_core #(
      .MAX_TEXT(MAX_TEXT)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .ch         (req_tdata),
      .wrap_width (wrap_width_ff),
      .step       (step)
   );

   // Result queue pointers and fill
   assign push_n    = req_accept ? step.count : 2'd0;
   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(rsp_accept);
   assign count_in  = count_ff + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage: up to two lines written per accepted character
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_mem_ff[wr_ptr_ff] <= step.res0;
      end
      if (push_n == 2'd2) begin
         q_mem_ff[wr_ptr_ff + QPTR_W'(1)] <= step.res1;
      end
   end

   // Head of queue drives the result channel
   assign head       = q_mem_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {head.widest_line, head.line_number, head.line_length, head.line_start};
   assign rsp_tlast  = head.last;

   // Queue never overfills
   `GWWS_ASSERT_IMPLY(a_q_bound, clock, reset, 1'b1, count_ff <= (QPTR_W+1)'(QDEPTH))
   // Pushing two lines needs two free entries
   `GWWS_ASSERT_IMPLY(a_q_room, clock, reset, push_n == 2'd2, count_ff <= (QPTR_W+1)'(QDEPTH - 2))

endmodule

>>> hdl/gwws_core.sv
// Wrap state registers and the per-character line decision logic.
`include "greedy_word_wrap_spans_macros.svh"

module gwws_core import gwws_pkg::*; #(
   parameter int MAX_TEXT = MAX_TEXT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   ch,
   input  logic [15:0]  wrap_width,
   output step_out_type step
);

   localparam int POS_W = $clog2(MAX_TEXT);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] line_begin_ff, line_begin_in;
   logic [POS_W-1:0] group_begin_ff, group_begin_in;
   logic [15:0]      line_len_ff, line_len_in;
   logic [15:0]      space_run_ff, space_run_in;
   logic [15:0]      word_run_ff, word_run_in;
   logic             in_word_ff, in_word_in;
   logic [15:0]      lines_ff, lines_in;
   logic [15:0]      widest_ff, widest_in;

   logic             is_end, is_nl, is_sp;
   logic             do_fg, fg_break, emit_a, emit_b;
   logic [POS_W-1:0] fg_gb, lb1, b_start, pos_inc;
   logic [17:0]      total;
   logic [15:0]      ll1, widest_a, widest_b, num_b;
   rsp_item_type     item_a, item_b;

   // Character class
   assign is_end = (ch == CH_END);
   assign is_nl  = (ch == CH_LF) || (ch == CH_CR);
   assign is_sp  = (ch == CH_SPACE);

   // Group close: does this character end a pending group
   always_comb begin
      priority if (is_end) begin
         do_fg = (word_run_ff != 16'd0);
      end else if (is_nl) begin
         do_fg = (space_run_ff != 16'd0) || (word_run_ff != 16'd0);
      end else if (is_sp) begin
         do_fg = in_word_ff;
      end else begin
         do_fg = 1'b0;
      end
   end

   assign fg_gb    = (is_nl && !in_word_ff) ? pos_ff : group_begin_ff;
   assign total    = {2'b00, line_len_ff} + {2'b00, space_run_ff} + {2'b00, word_run_ff};
   assign fg_break = do_fg && (line_len_ff != 16'd0) && (total > {2'b00, wrap_width});

   // Line after the group is placed
   always_comb begin
      if (!do_fg) begin
         lb1 = line_begin_ff;
         ll1 = line_len_ff;
      end else if ((line_len_ff == 16'd0) || fg_break) begin
         lb1 = fg_gb;
         ll1 = word_run_ff;
      end else begin
         lb1 = line_begin_ff;
         ll1 = (total > {2'b00, SAT16}) ? SAT16 : total[15:0];
      end
   end

   // Emitted lines: first the one pushed out by the group, then a forced one
   assign emit_a   = fg_break;
   assign emit_b   = is_end ? (ll1 != 16'd0) : is_nl;
   assign b_start  = (is_nl && (ll1 == 16'd0)) ? pos_ff : lb1;
   assign widest_a = (emit_a && (line_len_ff > widest_ff)) ? line_len_ff : widest_ff;
   assign widest_b = (emit_b && (ll1 > widest_a)) ? ll1 : widest_a;
   assign num_b    = emit_a ? lines_ff + 16'd1 : lines_ff;

   always_comb begin
      item_a.last        = !emit_b;
      item_a.widest_line = widest_a;
      item_a.line_number = lines_ff;
      item_a.line_length = line_len_ff;
      item_a.line_start  = 16'(line_begin_ff);
      item_b.last        = 1'b1;
      item_b.widest_line = widest_b;
      item_b.line_number = num_b;
      item_b.line_length = ll1;
      item_b.line_start  = 16'(b_start);
      step.count = {1'b0, emit_a} + {1'b0, emit_b};
      step.res0  = emit_a ? item_a : item_b;
      step.res1  = item_b;
   end

   assign pos_inc = (pos_ff == POS_W'(MAX_TEXT - 1)) ? '0 : pos_ff + POS_W'(1);

   // Next state
   always_comb begin
      pos_in         = pos_inc;
      line_begin_in  = lb1;
      line_len_in    = ll1;
      group_begin_in = group_begin_ff;
      space_run_in   = do_fg ? 16'd0 : space_run_ff;
      word_run_in    = do_fg ? 16'd0 : word_run_ff;
      in_word_in     = do_fg ? 1'b0 : in_word_ff;
      lines_in       = lines_ff + {15'd0, emit_a} + {15'd0, emit_b};
      widest_in      = widest_b;
      priority if (is_end) begin
         pos_in         = '0;
         line_begin_in  = '0;
         line_len_in    = 16'd0;
         group_begin_in = '0;
         space_run_in   = 16'd0;
         word_run_in    = 16'd0;
         in_word_in     = 1'b0;
         lines_in       = 16'd0;
         widest_in      = 16'd0;
      end else if (is_nl) begin
         line_begin_in = b_start;
         line_len_in   = 16'd0;
         space_run_in  = 16'd0;
         word_run_in   = 16'd0;
         in_word_in    = 1'b0;
      end else if (is_sp) begin
         space_run_in = (space_run_in == SAT16) ? SAT16 : space_run_in + 16'd1;
      end else begin
         if (!in_word_ff) begin
            group_begin_in = pos_ff;
         end
         in_word_in  = 1'b1;
         word_run_in = (word_run_ff == SAT16) ? SAT16 : word_run_ff + 16'd1;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         line_begin_ff  <= '0;
         group_begin_ff <= '0;
         line_len_ff    <= 16'd0;
         space_run_ff   <= 16'd0;
         word_run_ff    <= 16'd0;
         in_word_ff     <= 1'b0;
         lines_ff       <= 16'd0;
         widest_ff      <= 16'd0;
      end else if (accept) begin
         pos_ff         <= pos_in;
         line_begin_ff  <= line_begin_in;
         group_begin_ff <= group_begin_in;
         line_len_ff    <= line_len_in;
         space_run_ff   <= space_run_in;
         word_run_ff    <= word_run_in;
         in_word_ff     <= in_word_in;
         lines_ff       <= lines_in;
         widest_ff      <= widest_in;
      end
   end

   // Two lines from one character only at a newline or end of text
   `GWWS_ASSERT_IMPLY(a_two_only_at_break, clock, reset, step.count == 2'd2, is_nl || is_end)
   // End of text restarts position and line numbering
   `GWWS_ASSERT_NEXT(a_end_clears, clock, reset, accept && is_end, pos_ff == '0 && lines_ff == 16'd0)
   // A pending word always means the word flag is set
   `GWWS_ASSERT_IMPLY(a_word_flag, clock, reset, word_run_ff != 16'd0, in_word_ff)

endmodule
